FILE: design/ucep_pkg.sv
// ----------------------------------------------------------------------------
// ucep_pkg
// Shared types, codes and defaults of the endpoint-zero control sequencer.
// ----------------------------------------------------------------------------
package ucep_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_PACKET        = 64;
    localparam int DEF_CONFIG_DESC_LEN   = 41;

    // Reset value of the device descriptor length register
    localparam logic [7:0] DEV_DESC_LEN_RESET = 8'd18;

    // Standard request decoding
    localparam logic [1:0] REQ_TYPE_STANDARD  = 2'd0;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] DESC_TYPE_DEVICE   = 8'd1;
    localparam logic [7:0] DESC_TYPE_CONFIG   = 8'd2;

    // Configuration register word index
    localparam logic REG_DEV_DESC_LEN = 1'b0;

    typedef enum logic [1:0] {
        EV_BUS_RESET = 2'd0,
        EV_SETUP     = 2'd1,
        EV_IN_DONE   = 2'd2,
        EV_OUT_DONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ACT_DATA = 2'd0,
        ACT_ZLP  = 2'd1,
        ACT_ARM  = 2'd2,
        ACT_ADDR = 2'd3
    } t_action;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  request_type;
        logic [7:0]  request;
        logic [15:0] setup_value;
        logic [15:0] setup_length;
    } t_event;

    typedef struct packed {
        t_action    action;
        logic       descriptor_id;
        logic [7:0] byte_offset;
        logic [6:0] packet_length;
        logic [6:0] device_address;
        logic       last;
    } t_result;

    // One event's worth of results handed to the output queue
    typedef struct packed {
        logic              valid;
        logic [1:0]        count;
        t_result [2:0]     res;
    } t_qload;

    function automatic t_result mk_result(t_action a, logic d, logic [7:0] off,
                                          logic [6:0] len, logic [6:0] addr);
        t_result r;
        r.action         = a;
        r.descriptor_id  = d;
        r.byte_offset    = off;
        r.packet_length  = len;
        r.device_address = addr;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

FILE: design/ucep_regs.sv
// ----------------------------------------------------------------------------
// ucep_regs
// APB register file: device descriptor length.
// ----------------------------------------------------------------------------
module ucep_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_dev_len
);
    import ucep_pkg::*;

    logic [7:0] r_dev_len;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DEV_DESC_LEN);

    // Hold the register; take a write on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_len <= DEV_DESC_LEN_RESET;
        end else if (wr_en) begin
            r_dev_len <= pwdata[7:0];
        end
    end

    // Read back; unmapped words read zero
    assign prdata    = (paddr[2] == REG_DEV_DESC_LEN) ? {24'd0, r_dev_len} : 32'd0;
    assign o_dev_len = r_dev_len;

endmodule

FILE: design/ucep_core.sv
// ----------------------------------------------------------------------------
// ucep_core
// Event input register and single-pass request handling into a result set.
// ----------------------------------------------------------------------------
module ucep_core #(
    parameter int MAX_PACKET               = ucep_pkg::DEF_MAX_PACKET,
    parameter int CONFIG_DESCRIPTOR_LENGTH = ucep_pkg::DEF_CONFIG_DESC_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ucep_pkg::t_event i_event,
    input  logic [7:0]       i_dev_len,
    input  logic             i_q_free,
    output ucep_pkg::t_qload o_load
);
    import ucep_pkg::*;

    localparam logic [7:0] MAXP     = 8'(MAX_PACKET);
    localparam logic [7:0] CFG_LEN  = 8'(CONFIG_DESCRIPTOR_LENGTH);
    localparam int         NUM_MULT = 255 / MAX_PACKET + 1;

    typedef enum logic [1:0] {
        STAGE_SETUP  = 2'd0,
        STAGE_DATA   = 2'd1,
        STAGE_STATUS = 2'd2
    } t_stage;

    // Input register
    logic   r_in_valid;
    t_event r_in;
    logic   advance;

    // Transfer state
    t_stage     r_stage,   n_stage;
    logic [7:0] r_bytes,   n_bytes;
    logic [7:0] r_offset,  n_offset;
    logic       r_sel,     n_sel;
    logic       r_zlp_due, n_zlp_due;
    logic [6:0] r_pend,    n_pend;

    t_result [2:0] n_res;
    logic [1:0]    n_cnt;

    assign advance = r_in_valid && i_q_free;
    assign o_ready = !r_in_valid || advance;

    // Capture the next event whenever the register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_event;
        end
    end

    // Handle the registered event and build its results
    always_comb begin
        logic [7:0] dlen;
        logic [6:0] plen;
        logic       do_data;
        logic       mult;
        n_stage   = r_stage;
        n_bytes   = r_bytes;
        n_offset  = r_offset;
        n_sel     = r_sel;
        n_zlp_due = r_zlp_due;
        n_pend    = r_pend;
        n_res     = '0;
        n_cnt     = 2'd0;
        do_data   = 1'b0;
        mult      = 1'b0;
        dlen      = 8'd0;
        plen      = 7'd0;
        case (r_in.kind)
            EV_BUS_RESET: begin
                n_pend = 7'd0;
            end
            EV_SETUP: begin
                n_bytes   = 8'd0;
                n_offset  = 8'd0;
                n_zlp_due = 1'b0;
                n_stage   = STAGE_SETUP;
                if (r_in.request_type[6:5] == REQ_TYPE_STANDARD) begin
                    if (r_in.request == REQ_SET_ADDRESS) begin
                        n_pend = r_in.setup_value[6:0];
                    end else if (r_in.request == REQ_GET_DESCRIPTOR) begin
                        if (r_in.setup_value[15:8] == DESC_TYPE_DEVICE) begin
                            n_sel   = 1'b0;
                            n_bytes = i_dev_len;
                        end else if (r_in.setup_value[15:8] == DESC_TYPE_CONFIG) begin
                            n_sel   = 1'b1;
                            n_bytes = CFG_LEN;
                        end
                    end
                end
                // Clamp to what the host asked for
                if ({8'd0, n_bytes} > r_in.setup_length) begin
                    n_bytes = r_in.setup_length[7:0];
                end
                // Whole number of packets
                for (int k = 0; k < NUM_MULT; k++) begin
                    if (n_bytes == 8'(k * MAX_PACKET)) begin
                        mult = 1'b1;
                    end
                end
                if (r_in.setup_length != 16'd0) begin
                    n_stage = STAGE_DATA;
                    if (r_in.request_type[7]) begin
                        if (r_in.setup_length > {8'd0, n_bytes} && mult) begin
                            n_zlp_due = 1'b1;
                        end
                        do_data = 1'b1;
                    end else begin
                        n_res[n_cnt] = mk_result(ACT_ARM, 1'b0, 8'd0, 7'd0, 7'd0);
                        n_cnt        = n_cnt + 2'd1;
                    end
                end else begin
                    n_res[n_cnt] = mk_result(ACT_ZLP, 1'b0, 8'd0, 7'd0, 7'd0);
                    n_cnt        = n_cnt + 2'd1;
                end
            end
            EV_IN_DONE: begin
                do_data = 1'b1;
            end
            default: begin
                n_res[n_cnt] = mk_result(ACT_ARM, 1'b0, 8'd0, 7'd0, 7'd0);
                n_cnt        = n_cnt + 2'd1;
            end
        endcase

        // Data IN stage: next packet, or close out with an optional ZLP
        if (do_data) begin
            if (n_bytes == 8'd0) begin
                if (n_zlp_due) begin
                    n_res[n_cnt] = mk_result(ACT_ZLP, 1'b0, 8'd0, 7'd0, 7'd0);
                    n_cnt        = n_cnt + 2'd1;
                    n_zlp_due    = 1'b0;
                end
                n_stage      = STAGE_STATUS;
                n_res[n_cnt] = mk_result(ACT_ARM, 1'b0, 8'd0, 7'd0, 7'd0);
                n_cnt        = n_cnt + 2'd1;
            end else begin
                dlen         = (n_bytes > MAXP) ? MAXP : n_bytes;
                plen         = dlen[6:0];
                n_res[n_cnt] = mk_result(ACT_DATA, n_sel, n_offset, plen, 7'd0);
                n_cnt        = n_cnt + 2'd1;
                n_res[n_cnt] = mk_result(ACT_ARM, 1'b0, 8'd0, 7'd0, 7'd0);
                n_cnt        = n_cnt + 2'd1;
                n_offset     = n_offset + dlen;
                n_bytes      = n_bytes - dlen;
            end
        end

        // Apply a latched address after an IN completion
        if (r_in.kind == EV_IN_DONE && n_pend != 7'd0) begin
            n_res[n_cnt] = mk_result(ACT_ADDR, 1'b0, 8'd0, 7'd0, n_pend);
            n_cnt        = n_cnt + 2'd1;
            n_pend       = 7'd0;
        end

        if (n_cnt != 2'd0) begin
            n_res[n_cnt - 2'd1].last = 1'b1;
        end
    end

    // Advance transfer state once the results are handed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage   <= STAGE_SETUP;
            r_bytes   <= 8'd0;
            r_offset  <= 8'd0;
            r_sel     <= 1'b0;
            r_zlp_due <= 1'b0;
            r_pend    <= 7'd0;
        end else if (advance) begin
            r_stage   <= n_stage;
            r_bytes   <= n_bytes;
            r_offset  <= n_offset;
            r_sel     <= n_sel;
            r_zlp_due <= n_zlp_due;
            r_pend    <= n_pend;
        end
    end

    assign o_load.valid = advance;
    assign o_load.count = n_cnt;
    assign o_load.res   = n_res;

    // Status stage means the data stage has drained
    a_status_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage == STAGE_STATUS |-> r_bytes == 8'd0 && !r_zlp_due)
        else $error("status stage with data still pending");

    // Only a bus reset yields no results
    a_empty_only_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> ((n_cnt == 2'd0) == (r_in.kind == EV_BUS_RESET)))
        else $error("result count does not match event kind");

    // Data packets are never empty and never exceed the packet size
    a_packet_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_cnt != 2'd0 && n_res[0].action == ACT_DATA |->
            n_res[0].packet_length != 7'd0 && {1'b0, n_res[0].packet_length} <= MAXP)
        else $error("data packet length out of range");

endmodule

FILE: design/ucep_outq.sv
// ----------------------------------------------------------------------------
// ucep_outq
// Result queue: holds one event's results and sends them one beat a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module ucep_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ucep_pkg::t_qload  i_load,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output ucep_pkg::t_result o_result
);
    import ucep_pkg::*;

    t_result [2:0] r_q;
    logic [1:0]    r_cnt;
    logic          pop;

    assign o_valid  = (r_cnt != 2'd0);
    assign pop      = o_valid && i_ready;
    assign o_free   = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign o_result = r_q[0];

    // Reload from the core, or drop the head beat once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load.valid) begin
            r_cnt <= i_load.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.valid) begin
            r_q <= i_load.res;
        end else if (pop) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

    // A load only lands on an empty or emptying queue
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.valid |-> r_cnt == 2'd0 || (r_cnt == 2'd1 && i_ready))
        else $error("result queue overwritten");

    // The final queued beat closes its event
    a_tail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd1 |-> r_q[0].last)
        else $error("final beat without last");

    // Earlier beats never close the event
    a_head_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt > 2'd1 |-> !r_q[0].last)
        else $error("last raised before final beat");

endmodule

FILE: design/usb_control_endpoint_sequencer.sv
// ----------------------------------------------------------------------------
// usb_control_endpoint_sequencer
// Endpoint-zero control transfer sequencer driven by bus events.
// ----------------------------------------------------------------------------
// Usage:
//   Events (bus reset, setup, IN done, OUT done) enter on the s_axis channel;
//   s_axis_tuser carries the event kind, s_axis_tdata the setup fields.
//   Each event yields zero to three actions on m_axis, one beat per action,
//   with m_axis_tlast on the final beat of the event. A bus reset yields none.
//   The event beat is taken into the input register, one pass then loads
//   the result queue, and the first result beat is sent from the queue.
//   Throughput: one event per cycle while each yields at most one beat and
//   m_axis_tready stays high; otherwise the output port sets the pace at one
//   beat a cycle. The input register can take the next event while results
//   are still being sent.
//   Stall: with m_axis_tready low the queue holds its beat, the next event
//   waits in the input register, and s_axis_tready drops once both are full.
//   Reset: synchronous, active low; the transfer state clears, the pending
//   address clears and the descriptor length register returns to 18.
//   The APB port holds the device descriptor length at address 0.
// ----------------------------------------------------------------------------
module usb_control_endpoint_sequencer #(
    parameter int MAX_PACKET               = ucep_pkg::DEF_MAX_PACKET,
    parameter int CONFIG_DESCRIPTOR_LENGTH = ucep_pkg::DEF_CONFIG_DESC_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Event channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // request_type[7:0], request[15:8],
                                        // setup_value[31:16], setup_length[47:32]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    // Action channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // descriptor_id[0], byte_offset[8:1],
                                        // packet_length[15:9], device_address[22:16],
                                        // zero fill[23]
    output logic [1:0]  m_axis_tuser,   // action[1:0]
    output logic        m_axis_tlast,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ucep_pkg::*;

    t_event     ev;
    t_qload     qload;
    t_result    res;
    logic       q_free;
    logic [7:0] dev_len;

    assign ev.kind         = t_kind'(s_axis_tuser);
    assign ev.request_type = s_axis_tdata[7:0];
    assign ev.request      = s_axis_tdata[15:8];
    assign ev.setup_value  = s_axis_tdata[31:16];
    assign ev.setup_length = s_axis_tdata[47:32];

    ucep_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_dev_len (dev_len)
    );

    ucep_core #(
        .MAX_PACKET               (MAX_PACKET),
        .CONFIG_DESCRIPTOR_LENGTH (CONFIG_DESCRIPTOR_LENGTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_event   (ev),
        .i_dev_len (dev_len),
        .i_q_free  (q_free),
        .o_load    (qload)
    );

    ucep_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (qload),
        .o_free   (q_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (res)
    );

    // Pack the head beat onto the action channel
    assign m_axis_tuser = res.action;
    assign m_axis_tlast = res.last;
    assign m_axis_tdata = {1'b0, res.device_address, res.packet_length,
                           res.byte_offset, res.descriptor_id};

endmodule

FILE: test/usb_control_endpoint_sequencer_test.sv
// ----------------------------------------------------------------------------
// usb_control_endpoint_sequencer_test
// Self-checking bench for the endpoint-zero control transfer sequencer.
//
// Events go in on the s_axis side under random gaps. A behavioral copy of
// the sequencer works out the action beats that each event should produce,
// and every beat on m_axis is compared field by field with the oldest one
// still expected. A short hand-written table covers the corner requests
// first. Random transfers follow under several descriptor lengths, set over
// APB while the block is idle. Once in the run the receiver holds off long
// enough to fill the block and stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module usb_control_endpoint_sequencer_test;
    import ucep_pkg::*;

    localparam int MAX_PKT          = DEF_MAX_PACKET;
    localparam int CONFIG_LEN       = DEF_CONFIG_DESC_LEN;
    localparam int SETTLE_CYCLES    = 6;
    localparam int HOLD_OFF_CYCLES  = 150;
    localparam int STALL_LIMIT      = 2000;
    localparam int MAX_REPORTS      = 10;
    localparam int N_PHASES         = 6;
    localparam int ITEMS_PER_PHASE  = 35;
    localparam logic [2:0] DESC_LEN_ADDR = 3'(4 * REG_DEV_DESC_LEN);

    // Transfer stage of the behavioral copy
    typedef enum logic [1:0] {
        XFER_SETUP  = 2'd0,
        XFER_DATA   = 2'd1,
        XFER_STATUS = 2'd2
    } t_xfer_stage;

    // One row of the directed table; typed_res slot 0 is the first beat
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  request_type;
        logic [7:0]  request;
        logic [15:0] setup_value;
        logic [15:0] setup_length;
        logic        typed;
        logic [1:0]  n_typed;
        t_result [2:0] typed_res;
    } t_directed_row;

    localparam t_result NO_ACT       = '{ACT_DATA, 1'b0, 8'd0, 7'd0, 7'd0, 1'b0};
    localparam t_result ARM_ONLY     = '{ACT_ARM,  1'b0, 8'd0, 7'd0, 7'd0, 1'b0};
    localparam t_result ARM_LAST     = '{ACT_ARM,  1'b0, 8'd0, 7'd0, 7'd0, 1'b1};
    localparam t_result ZLP_LAST     = '{ACT_ZLP,  1'b0, 8'd0, 7'd0, 7'd0, 1'b1};
    localparam t_result ADDR_7F_LAST = '{ACT_ADDR, 1'b0, 8'd0, 7'd0, 7'h7F, 1'b1};

    localparam int N_DIRECTED = 23;
    localparam t_directed_row DIRECTED_ROWS [N_DIRECTED] = '{
        // IN and OUT done straight after reset: arm only
        '{EV_IN_DONE,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 2'd1,
          {NO_ACT, NO_ACT, ARM_LAST}},
        '{EV_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 2'd1,
          {NO_ACT, NO_ACT, ARM_LAST}},
        // highest address, applied after the next IN done
        '{EV_SETUP,    8'h00, 8'h05, 16'h007F, 16'h0000, 1'b1, 2'd1,
          {NO_ACT, NO_ACT, ZLP_LAST}},
        '{EV_IN_DONE,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 2'd2,
          {NO_ACT, ADDR_7F_LAST, ARM_ONLY}},
        // bus reset drops a latched address and gives no beat
        '{EV_SETUP,    8'h00, 8'h05, 16'hFF85, 16'h0000, 1'b1, 2'd1,
          {NO_ACT, NO_ACT, ZLP_LAST}},
        '{EV_BUS_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 2'd0,
          {NO_ACT, NO_ACT, NO_ACT}},
        '{EV_IN_DONE,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 2'd1,
          {NO_ACT, NO_ACT, ARM_LAST}},
        // device and configuration descriptors, full and clamped
        '{EV_SETUP,    8'h80, 8'h06, 16'h0100, 16'hFFFF, 1'b0, 2'd0, '0},
        '{EV_IN_DONE,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 2'd0, '0},
        '{EV_SETUP,    8'h80, 8'h06, 16'h0200, 16'h0029, 1'b0, 2'd0, '0},
        '{EV_SETUP,    8'h80, 8'h06, 16'h0200, 16'h0009, 1'b0, 2'd0, '0},
        '{EV_IN_DONE,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 2'd0, '0},
        // unknown descriptor type, class and reserved-type requests
        '{EV_SETUP,    8'h80, 8'h06, 16'h0300, 16'h0010, 1'b0, 2'd0, '0},
        '{EV_SETUP,    8'hA1, 8'h06, 16'h0100, 16'h0008, 1'b0, 2'd0, '0},
        '{EV_SETUP,    8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 2'd0, '0},
        // no-data standard request, OUT data stage
        '{EV_SETUP,    8'h00, 8'h09, 16'h0001, 16'h0000, 1'b0, 2'd0, '0},
        '{EV_SETUP,    8'h21, 8'h09, 16'h0200, 16'hFFFF, 1'b0, 2'd0, '0},
        '{EV_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 2'd0, '0},
        // one-byte request
        '{EV_SETUP,    8'h80, 8'h06, 16'h01FF, 16'h0001, 1'b0, 2'd0, '0},
        // address latched across a data stage: two beats on IN done
        '{EV_SETUP,    8'h00, 8'h05, 16'h0001, 16'h0000, 1'b0, 2'd0, '0},
        '{EV_SETUP,    8'h80, 8'h06, 16'h0100, 16'h0040, 1'b0, 2'd0, '0},
        '{EV_IN_DONE,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 2'd0, '0},
        '{EV_OUT_DONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 2'd0, '0}
    };

    localparam int FIXED_SETTINGS [4] = '{0, 255, 64, 128};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // request_type, request, setup_value, setup_length
    logic [1:0]  s_axis_tuser = '0;    // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // descriptor_id, byte_offset, packet_length,
                                       // device_address, zero fill
    logic [1:0]  m_axis_tuser;         // action
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    usb_control_endpoint_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Behavioral copy of the sequencer state
    logic [7:0]  desc_len_setting = DEV_DESC_LEN_RESET;
    t_xfer_stage xfer_stage = XFER_SETUP;
    logic [7:0]  bytes_left = '0;
    logic [7:0]  next_offset = '0;
    logic        desc_sel = 1'b0;
    logic        zlp_owed = 1'b0;
    logic [6:0]  address_pending = '0;

    t_result expected_actions [$];

    int  fault_count = 0;
    int  events_sent = 0;
    int  beats_checked = 0;
    int  data_beats = 0;
    int  zlp_beats = 0;
    int  addr_beats = 0;
    int  stall_cycles = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;
    bit  hold_off_req = 1'b0;
    bit  hold_off_done = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result make_action(t_action act, logic desc, logic [7:0] off,
                                            logic [6:0] len, logic [6:0] addr);
        t_result r;
        r.action         = act;
        r.descriptor_id  = desc;
        r.byte_offset    = off;
        r.packet_length  = len;
        r.device_address = addr;
        r.last           = 1'b0;
        return r;
    endfunction

    function automatic t_event make_event(t_kind kind, logic [7:0] rtype, logic [7:0] req,
                                          logic [15:0] value, logic [15:0] length);
        t_event ev;
        ev.kind         = kind;
        ev.request_type = rtype;
        ev.request      = req;
        ev.setup_value  = value;
        ev.setup_length = length;
        return ev;
    endfunction

    // Send the next packet of the data IN stage, or close it out
    task automatic serve_in_packet();
        logic [7:0] chunk;
        if (bytes_left == 8'd0) begin
            if (zlp_owed) begin
                expected_actions.push_back(make_action(ACT_ZLP, 1'b0, 8'd0, 7'd0, 7'd0));
                zlp_owed = 1'b0;
            end
            xfer_stage = XFER_STATUS;
            expected_actions.push_back(make_action(ACT_ARM, 1'b0, 8'd0, 7'd0, 7'd0));
        end else begin
            chunk = (bytes_left > MAX_PKT) ? 8'(MAX_PKT) : bytes_left;
            expected_actions.push_back(make_action(ACT_DATA, desc_sel, next_offset,
                                                   chunk[6:0], 7'd0));
            expected_actions.push_back(make_action(ACT_ARM, 1'b0, 8'd0, 7'd0, 7'd0));
            next_offset = next_offset + chunk;
            bytes_left  = bytes_left - chunk;
        end
    endtask

    // Advance the copy by one event and queue the beats it should produce
    task automatic sequence_event(t_event ev);
        int base;
        base = expected_actions.size();
        case (ev.kind)
            EV_BUS_RESET: begin
                address_pending = '0;
            end
            EV_SETUP: begin
                bytes_left  = '0;
                next_offset = '0;
                zlp_owed    = 1'b0;
                xfer_stage  = XFER_SETUP;
                if (ev.request_type[6:5] == REQ_TYPE_STANDARD) begin
                    if (ev.request == REQ_SET_ADDRESS) begin
                        address_pending = ev.setup_value[6:0];
                    end else if (ev.request == REQ_GET_DESCRIPTOR) begin
                        if (ev.setup_value[15:8] == DESC_TYPE_DEVICE) begin
                            desc_sel   = 1'b0;
                            bytes_left = desc_len_setting;
                        end else if (ev.setup_value[15:8] == DESC_TYPE_CONFIG) begin
                            desc_sel   = 1'b1;
                            bytes_left = 8'(CONFIG_LEN);
                        end
                    end
                end
                // clamp to what the host asked for
                if (16'(bytes_left) > ev.setup_length) bytes_left = ev.setup_length[7:0];
                if (ev.setup_length != 16'd0) begin
                    xfer_stage = XFER_DATA;
                    // bit 7 set: device to host
                    if (ev.request_type[7]) begin
                        if (ev.setup_length > 16'(bytes_left) && (bytes_left % MAX_PKT) == 0)
                            zlp_owed = 1'b1;
                        serve_in_packet();
                    end else begin
                        expected_actions.push_back(
                            make_action(ACT_ARM, 1'b0, 8'd0, 7'd0, 7'd0));
                    end
                end else begin
                    expected_actions.push_back(make_action(ACT_ZLP, 1'b0, 8'd0, 7'd0, 7'd0));
                end
            end
            EV_IN_DONE: begin
                serve_in_packet();
                if (address_pending != 7'd0) begin
                    expected_actions.push_back(
                        make_action(ACT_ADDR, 1'b0, 8'd0, 7'd0, address_pending));
                    address_pending = '0;
                end
            end
            default: begin
                expected_actions.push_back(make_action(ACT_ARM, 1'b0, 8'd0, 7'd0, 7'd0));
            end
        endcase
        if (expected_actions.size() > base)
            expected_actions[expected_actions.size() - 1].last = 1'b1;
    endtask

    task automatic report_fault(string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Offer one event beat and hold it until it is taken
    task automatic send_event(t_event ev);
        int gap;
        if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ev.setup_length, ev.setup_value, ev.request, ev.request_type};
        s_axis_tuser  <= ev.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        events_sent++;
    endtask

    task automatic issue(t_event ev);
        sequence_event(ev);
        send_event(ev);
    endtask

    // Drop valid and wait until every expected beat is out and the block is quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_actions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the device descriptor length over APB, then read it back
    task automatic program_desc_len(logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DESC_LEN_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        desc_len_setting = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== 32'(value))
            report_fault($sformatf("descriptor length readback: expected %0d, got %0d",
                                   value, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [15:0] pick_length();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'($urandom_range(1, 70));
            2:       return 16'($urandom_range(1, 4) * MAX_PKT);
            3:       return 16'($urandom_range(0, 65535));
            4:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 300));
        endcase
    endfunction

    // Random traffic: mostly whole transfers with random content, some noise
    task automatic run_random_phase(int n_items);
        int start;
        int choice;
        logic [7:0] dtype;
        start = events_sent;
        while (events_sent - start < n_items) begin
            choice = $urandom_range(0, 99);
            if (choice < 45) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: dtype = DESC_TYPE_DEVICE;
                    4, 5, 6, 7: dtype = DESC_TYPE_CONFIG;
                    default:    dtype = 8'($urandom);
                endcase
                issue(make_event(EV_SETUP,
                                 {1'($urandom_range(0, 4) != 0), 2'b00, 5'($urandom)},
                                 REQ_GET_DESCRIPTOR, {dtype, 8'($urandom)}, pick_length()));
                repeat ($urandom_range(0, 6)) issue(make_event(EV_IN_DONE, 8'($urandom),
                    8'($urandom), 16'($urandom), 16'($urandom)));
                if ($urandom_range(0, 1) == 0)
                    issue(make_event(EV_OUT_DONE, '0, '0, '0, '0));
            end else if (choice < 60) begin
                issue(make_event(EV_SETUP, {1'($urandom), 2'b00, 5'($urandom)},
                                 REQ_SET_ADDRESS, 16'($urandom),
                                 ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 8))
                                                             : 16'd0));
                if ($urandom_range(0, 4) == 0) issue(make_event(EV_BUS_RESET, '0, '0, '0, '0));
                issue(make_event(EV_IN_DONE, '0, '0, '0, '0));
            end else if (choice < 72) begin
                issue(make_event(EV_SETUP, {1'b0, 2'($urandom), 5'($urandom)}, 8'($urandom),
                                 16'($urandom), 16'($urandom_range(1, 512))));
                repeat ($urandom_range(1, 3)) issue(make_event(EV_OUT_DONE, '0, '0, '0, '0));
                issue(make_event(EV_IN_DONE, '0, '0, '0, '0));
            end else begin
                issue(make_event(t_kind'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                                 16'($urandom), 16'($urandom)));
            end
        end
    endtask

    // Main sequence: reset, directed table, then random phases per setting
    initial begin
        t_directed_row row;
        t_event        ev;
        int            base;
        logic [7:0]    setting;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            ev  = make_event(row.kind, row.request_type, row.request,
                             row.setup_value, row.setup_length);
            base = expected_actions.size();
            sequence_event(ev);
            // keep the state advance, but check against the hand-written beats
            if (row.typed) begin
                while (expected_actions.size() > base) void'(expected_actions.pop_back());
                for (int k = 0; k < row.n_typed; k++)
                    expected_actions.push_back(row.typed_res[k]);
            end
            send_event(ev);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            setting = (p < 4) ? 8'(FIXED_SETTINGS[p]) : 8'($urandom_range(0, 255));
            program_desc_len(setting);
            // long packets in this phase: let the receiver back up the block
            if (p == 1) hold_off_req = 1'b1;
            run_random_phase(ITEMS_PER_PHASE);
        end

        settle();
        $display("Sent %0d events (%0d from the table) under %0d descriptor lengths.",
                 events_sent, N_DIRECTED, N_PHASES + 1);
        $display("Checked %0d beats: %0d data, %0d zero-length, %0d address; hold-off %s.",
                 beats_checked, data_beats, zlp_beats, addr_beats,
                 hold_off_done ? "done" : "missed");
        if (fault_count == 0 && expected_actions.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Receiver: random stalls per beat, one long hold-off on request
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_done = 1'b1;
            end
            if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    // Compare each action beat with the oldest expected one
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.action         = t_action'(m_axis_tuser);
            got.descriptor_id  = m_axis_tdata[0];
            got.byte_offset    = m_axis_tdata[8:1];
            got.packet_length  = m_axis_tdata[15:9];
            got.device_address = m_axis_tdata[22:16];
            got.last           = m_axis_tlast;
            beats_checked++;
            case (got.action)
                ACT_DATA: data_beats++;
                ACT_ZLP:  zlp_beats++;
                ACT_ADDR: addr_beats++;
                default: ;
            endcase
            if (expected_actions.size() == 0) begin
                report_fault($sformatf("unexpected beat act=%0d desc=%0d off=%0d len=%0d adr=%0d last=%0d",
                    got.action, got.descriptor_id, got.byte_offset, got.packet_length,
                    got.device_address, got.last));
            end else begin
                want = expected_actions.pop_front();
                if (got.action !== want.action || got.descriptor_id !== want.descriptor_id ||
                    got.byte_offset !== want.byte_offset ||
                    got.packet_length !== want.packet_length ||
                    got.device_address !== want.device_address || got.last !== want.last)
                    report_fault($sformatf(
                        "beat %0d exp act=%0d desc=%0d off=%0d len=%0d adr=%0d last=%0d, got act=%0d desc=%0d off=%0d len=%0d adr=%0d last=%0d",
                        beats_checked, want.action, want.descriptor_id, want.byte_offset,
                        want.packet_length, want.device_address, want.last,
                        got.action, got.descriptor_id, got.byte_offset,
                        got.packet_length, got.device_address, got.last));
            end
        end
    end

    // Watchdog: end the run when neither side moves a beat for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles, %0d beats still expected",
                         STALL_LIMIT, expected_actions.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule
